@@ hw/rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Used by every module under hw/rtl; depends on nothing else.
package tcw_pkg;

    // Default screen geometry in character cells.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // A cell holds the attribute in the high byte and the character in the low byte.
    localparam int CELL_W = 16;

    // Control characters with special meaning.
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Blank cell left in the store after reset.
    localparam logic [7:0]        RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    // Request codes carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Configuration register indexes.
    localparam logic CFG_FOREGROUND = 1'b0;
    localparam logic CFG_BACKGROUND = 1'b1;

    // Commands from the sequencer to the shared address counter.
    typedef struct packed {
        logic load;
        logic step;
    } t_cnt_ctrl;

endpackage

@@ hw/rtl/text_console_writer.sv @@
// Text console writer: request sequencer, cursor and result register.
// Depends on tcw_pkg, tcw_screen_ram and tcw_addr_unit.
//
// Requests arrive on the s_axis channel: tuser carries the request kind
// (put character, clear screen, read cell), tdata the character and the
// cell address. Each request gives exactly one result transfer on m_axis,
// carrying the cursor after the request, the cell read and a scroll flag.
// The block takes one request at a time and is not ready while it works.
// A put that scrolls copies every row up through the single store port
// pair, one cell a cycle, then blanks the bottom row. A clear writes every
// cell once. After reset the store is swept to blank cells with attribute
// 0x07, one cell a cycle; no request is taken meanwhile, but configuration
// writes are. When the receiver stalls, a finished result is held in the
// output register, and the block still takes the next request; that one
// completes only once the register has been emptied.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] char_code, [18:8] cell_address, zero pad
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [6:0] cursor_column, [11:7] cursor_row,
                                       // [22:12] cursor_position, [38:23] read_cell,
                                       // [39] scrolled
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [9:0] {
        S_INIT      = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_PUT       = 10'b00_0000_0100,
        S_READ      = 10'b00_0000_1000,
        S_RDDATA    = 10'b00_0001_0000,
        S_FILL      = 10'b00_0010_0000,
        S_COPY      = 10'b00_0100_0000,
        S_COPY_LAST = 10'b00_1000_0000,
        S_BLANK     = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_fg, r_bg;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [7:0]        r_char;
    logic [10:0]       r_addr;
    logic              r_scrolled, n_scrolled;
    logic [CELL_W-1:0] r_rdata, n_rdata;
    logic              r_fill_init, n_fill_init;
    logic [CELL_W-1:0] r_fill_value, n_fill_value;
    logic              r_cp_valid, n_cp_valid;
    logic [AW-1:0]     r_cp_addr, n_cp_addr;
    logic              r_out_valid, n_out_valid;
    logic [39:0]       r_out_data, n_out_data;

    logic [7:0]        attr;
    logic [CELL_W-1:0] blank;
    logic [AW-1:0]     row_base;
    logic [AW-1:0]     cur_pos;
    logic              addr_ok;

    // Put request datapath.
    logic [CW:0]       put_col;
    logic [RW:0]       put_row;
    logic              put_we;
    logic [AW-1:0]     put_waddr;
    logic [CELL_W-1:0] put_wdata;
    logic              put_scroll;

    // Store ports and counter.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;
    t_cnt_ctrl         cnt_ctrl;
    logic [AW-1:0]     cnt_load_value;
    logic [AW-1:0]     cnt;
    logic              cnt_last;

    tcw_screen_ram #(.CELLS(CELLS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcw_addr_unit #(.CELLS(CELLS), .AW(AW)) u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (cnt_ctrl),
        .i_load_value (cnt_load_value),
        .o_count      (cnt),
        .o_last       (cnt_last)
    );

    // Current attribute, blank cell and cursor address.
    assign attr     = {r_bg, r_fg};
    assign blank    = {attr, CH_SPACE};
    assign row_base = AW'(int'(r_row) * COLUMNS);
    assign cur_pos  = row_base + AW'(r_col);
    assign addr_ok  = (32'(r_addr) < CELLS);

    // Cursor movement and cell write for one put request.
    always_comb begin
        put_col   = {1'b0, r_col};
        put_row   = {1'b0, r_row};
        put_we    = 1'b0;
        put_waddr = cur_pos;
        put_wdata = {attr, r_char};
        case (r_char)
            CH_NEWLINE: begin
                put_col = '0;
                put_row = {1'b0, r_row} + (RW+1)'(1);
            end
            CH_RETURN: begin
                put_col = '0;
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    put_col   = {1'b0, r_col} - (CW+1)'(1);
                    put_we    = 1'b1;
                    put_waddr = cur_pos - AW'(1);
                    put_wdata = blank;
                end
            end
            default: begin
                put_we  = 1'b1;
                put_col = {1'b0, r_col} + (CW+1)'(1);
            end
        endcase
        if (put_col == (CW+1)'(COLUMNS)) begin
            put_col = '0;
            put_row = put_row + (RW+1)'(1);
        end
        put_scroll = (put_row == (RW+1)'(ROWS));
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= RESET_ATTR[3:0];
            r_bg <= RESET_ATTR[7:4];
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOREGROUND: r_fg <= i_cfg_data;
                CFG_BACKGROUND: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state        = r_state;
        n_col          = r_col;
        n_row          = r_row;
        n_scrolled     = r_scrolled;
        n_rdata        = r_rdata;
        n_fill_init    = r_fill_init;
        n_fill_value   = r_fill_value;
        n_cp_valid     = 1'b0;
        n_cp_addr      = r_cp_addr;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_out_data     = r_out_data;
        cnt_ctrl       = '0;
        cnt_load_value = '0;
        ram_we         = 1'b0;
        ram_waddr      = cnt;
        ram_wdata      = blank;
        ram_re         = 1'b0;
        ram_raddr      = cnt;
        s_axis_tready  = 1'b0;

        unique case (r_state)
            S_INIT, S_FILL: begin
                ram_we        = 1'b1;
                ram_wdata     = r_fill_value;
                cnt_ctrl.step = 1'b1;
                if (cnt_last) begin
                    n_state = r_fill_init ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_scrolled = 1'b0;
                    n_rdata    = '0;
                    unique case (t_req'(s_axis_tuser))
                        REQ_PUT:  n_state = S_PUT;
                        REQ_CLEAR: begin
                            n_state        = S_FILL;
                            n_fill_init    = 1'b0;
                            n_fill_value   = blank;
                            n_col          = '0;
                            n_row          = '0;
                            cnt_ctrl.load  = 1'b1;
                            cnt_load_value = '0;
                        end
                        REQ_READ: n_state = S_READ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                ram_we     = put_we;
                ram_waddr  = put_waddr;
                ram_wdata  = put_wdata;
                n_col      = put_col[CW-1:0];
                n_scrolled = put_scroll;
                if (put_scroll) begin
                    n_row          = RW'(ROWS - 1);
                    n_state        = S_COPY;
                    cnt_ctrl.load  = 1'b1;
                    cnt_load_value = AW'(COLUMNS);
                end else begin
                    n_row   = put_row[RW-1:0];
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_addr);
                n_state   = S_RDDATA;
            end
            S_RDDATA: begin
                n_rdata = addr_ok ? ram_rdata : '0;
                n_state = S_DONE;
            end
            S_COPY: begin
                // Read one row down while the previous read lands one row up.
                ram_re        = 1'b1;
                ram_we        = r_cp_valid;
                ram_waddr     = r_cp_addr;
                ram_wdata     = ram_rdata;
                n_cp_valid    = 1'b1;
                n_cp_addr     = cnt - AW'(COLUMNS);
                cnt_ctrl.step = 1'b1;
                if (cnt_last) begin
                    n_state = S_COPY_LAST;
                end
            end
            S_COPY_LAST: begin
                ram_we         = r_cp_valid;
                ram_waddr      = r_cp_addr;
                ram_wdata      = ram_rdata;
                cnt_ctrl.load  = 1'b1;
                cnt_load_value = AW'(CELLS - COLUMNS);
                n_state        = S_BLANK;
            end
            S_BLANK: begin
                ram_we        = 1'b1;
                cnt_ctrl.step = 1'b1;
                if (cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_scrolled, r_rdata, 11'(cur_pos), 5'(r_row), 7'(r_col)};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_col        <= '0;
            r_row        <= '0;
            r_fill_init  <= 1'b1;
            r_fill_value <= RESET_CELL;
            r_cp_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_fill_init  <= n_fill_init;
            r_fill_value <= n_fill_value;
            r_cp_valid   <= n_cp_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_char <= s_axis_tdata[7:0];
            r_addr <= s_axis_tdata[18:8];
        end
        r_scrolled <= n_scrolled;
        r_rdata    <= n_rdata;
        r_cp_addr  <= n_cp_addr;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ hw/rtl/tcw_screen_ram.sv @@
// Screen store of the text console writer: one write port, one registered read port.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int CELLS = DEF_COLUMNS * DEF_ROWS,
    parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tcw_addr_unit.sv @@
// Shared cell address counter that drives every sweep over the screen store.
// Depends on tcw_pkg for the control struct.
module tcw_addr_unit
    import tcw_pkg::*;
#(
    parameter int CELLS = DEF_COLUMNS * DEF_ROWS,
    parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cnt_ctrl     i_ctrl,
    input  logic [AW-1:0] i_load_value,
    output logic [AW-1:0] o_count,
    output logic          o_last
);

    logic [AW-1:0] r_count;
    logic [AW-1:0] n_count;

    // Load a start address or step by one cell.
    always_comb begin
        n_count = r_count;
        if (i_ctrl.load) begin
            n_count = i_load_value;
        end else if (i_ctrl.step) begin
            n_count = r_count + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Every sweep ends at the last cell of the store.
    assign o_count = r_count;
    assign o_last  = (r_count == AW'(CELLS - 1));

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the text console writer.
// Needs tcw_pkg and text_console_writer from the RTL; reads no files.
// Requests are driven as stream transfers and every result is checked against a predictor.
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    localparam int COLS  = DEF_COLUMNS;
    localparam int LINES = DEF_ROWS;
    localparam int CELLS = COLS * LINES;

    // One predicted result, field by field.
    typedef struct {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] pos;
        logic [15:0] rd_cell;
        logic        scrolled;
    } t_console_result;

    // Scoreboard: a private copy of the screen, the cursor and the colours.
    class t_console_scoreboard;
        logic [15:0]     screen [CELLS];
        int              cur_col;
        int              cur_row;
        logic [3:0]      fg;
        logic [3:0]      bg;
        t_console_result waiting [$];
        int              mismatches;

        function new();
            foreach (screen[i]) screen[i] = RESET_CELL;
            cur_col    = 0;
            cur_row    = 0;
            fg         = 4'd7;
            bg         = 4'd0;
            mismatches = 0;
        endfunction

        function logic [15:0] cell_with(logic [7:0] ch);
            return {bg, fg, ch};
        endfunction

        function void set_colour(logic index, logic [3:0] value);
            if (index == CFG_FOREGROUND) fg = value;
            else bg = value;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        // Applies one accepted request and queues the result it should give.
        function void note_request(t_req req, logic [7:0] ch, logic [10:0] addr);
            t_console_result r;
            r.rd_cell  = '0;
            r.scrolled = 1'b0;
            case (req)
                REQ_PUT: begin
                    if (ch == CH_NEWLINE) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (ch == CH_RETURN) begin
                        cur_col = 0;
                    end else if (ch == CH_BACKSPACE) begin
                        // Backspace at the left edge does nothing.
                        if (cur_col > 0) begin
                            cur_col--;
                            screen[cur_row * COLS + cur_col] = cell_with(CH_SPACE);
                        end
                    end else begin
                        screen[cur_row * COLS + cur_col] = cell_with(ch);
                        cur_col++;
                    end
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    // Leaving the bottom row moves every row up and blanks the last one.
                    if (cur_row >= LINES) begin
                        for (int i = COLS; i < CELLS; i++) screen[i - COLS] = screen[i];
                        for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = cell_with(CH_SPACE);
                        cur_row    = LINES - 1;
                        r.scrolled = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    foreach (screen[i]) screen[i] = cell_with(CH_SPACE);
                    cur_col = 0;
                    cur_row = 0;
                end
                REQ_READ: begin
                    // Addresses past the screen read as zero.
                    if (addr < CELLS) r.rd_cell = screen[addr];
                end
                default: ;
            endcase
            r.col = cur_col[6:0];
            r.row = cur_row[4:0];
            r.pos = 11'(cur_row * COLS + cur_col);
            waiting.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            if (mismatches < 50)
                $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        // Compares one result transfer with the oldest prediction.
        task check_result(logic [39:0] data);
            t_console_result want;
            if (waiting.size() == 0) begin
                report("result with no request outstanding", data, 0);
            end else begin
                want = waiting.pop_front();
                if (data[6:0] !== want.col) report("cursor_column", data[6:0], want.col);
                if (data[11:7] !== want.row) report("cursor_row", data[11:7], want.row);
                if (data[22:12] !== want.pos) report("cursor_position", data[22:12], want.pos);
                if (data[38:23] !== want.rd_cell) report("read_cell", data[38:23], want.rd_cell);
                if (data[39] !== want.scrolled) report("scrolled", data[39], want.scrolled);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [7:0] char_code, [18:8] cell_address, zero pad
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [6:0] column, [11:7] row, [22:12] position,
                                 // [38:23] read_cell, [39] scrolled
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [3:0]  i_cfg_data;

    t_console_scoreboard sb = new();
    bit                  idle_en = 1'b1;
    int                  items_sent = 0;

    text_console_writer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run including scroll and clear sweeps.
    initial begin
        #(200_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: checks each transfer, then, when idle_en is set, holds tready low at random.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                stall_left = idle_en ? $urandom_range(0, 4) : 0;
            end
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Offers one request, after a random gap when idle_en is set, and waits for its transfer.
    task automatic send(t_req req, logic [7:0] ch, logic [10:0] addr);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {5'd0, addr, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, ch, addr);
        items_sent++;
    endtask

    // Waits until every predicted result has arrived and the block has settled.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [3:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_colour(index, value);
    endtask

    task automatic set_colours(logic [3:0] fg, logic [3:0] bg);
        write_reg(CFG_FOREGROUND, fg);
        write_reg(CFG_BACKGROUND, bg);
        i_cfg_we <= 1'b0;
    endtask

    // A line of text with occasional edits and reads, usually closed by a newline.
    task automatic type_line();
        int len;
        int pick;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 100) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send(REQ_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
            else if (pick == 1)
                send(REQ_PUT, CH_RETURN, 11'($urandom_range(0, 2047)));
            else if (pick == 2)
                send(REQ_READ, 8'($urandom_range(0, 255)),
                     11'(sb.cur_row * COLS + $urandom_range(0, COLS - 1)));
            else
                send(REQ_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 9) != 0)
            send(REQ_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
    endtask

    // Stimulus.
    initial begin
        int target;
        int pick;
        logic [3:0] fg;
        logic [3:0] bg;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_PUT;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_FOREGROUND;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the reset colours.
        send(REQ_READ, 8'h00, 11'd0);
        send(REQ_READ, 8'hFF, 11'd1999);
        send(REQ_READ, 8'h00, 11'd2047);
        send(REQ_READ, 8'h00, 11'd2000);
        send(REQ_PUT, 8'h41, 11'h7FF);
        send(REQ_PUT, 8'h00, 11'd0);
        send(REQ_PUT, 8'hFF, 11'd0);
        send(REQ_PUT, CH_SPACE, 11'd0);
        send(REQ_READ, 8'h00, 11'd0);
        send(REQ_READ, 8'h00, 11'd2);
        send(REQ_PUT, CH_BACKSPACE, 11'd0);
        send(REQ_READ, 8'h00, 11'd3);
        send(REQ_PUT, CH_RETURN, 11'd0);
        send(REQ_PUT, CH_BACKSPACE, 11'd0);
        send(REQ_PUT, CH_NEWLINE, 11'd0);
        send(REQ_NONE, 8'hFF, 11'h7FF);
        send(REQ_PUT, 8'h7E, 11'd0);
        send(REQ_CLEAR, 8'hFF, 11'h7FF);
        send(REQ_READ, 8'h00, 11'd80);

        // Random phases, each under its own colours; the sender fully drains in between.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin fg = 4'd0;  bg = 4'd0;  end
                1: begin fg = 4'd15; bg = 4'd15; end
                2: begin fg = 4'd15; bg = 4'd0;  end
                3: begin fg = 4'd0;  bg = 4'd15; end
                default: begin
                    fg = 4'($urandom_range(0, 15));
                    bg = 4'($urandom_range(0, 15));
                end
            endcase
            set_colours(fg, bg);
            idle_en = (ph % 3 != 2);
            target  = items_sent + 190;
            while (items_sent < target) begin
                pick = $urandom_range(0, 199);
                if (pick < 140) begin
                    type_line();
                end else if (pick < 170) begin
                    send(t_req'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         11'($urandom_range(0, 2047)));
                end else if (pick < 186) begin
                    send(REQ_READ, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 1999)));
                end else if (pick < 188) begin
                    send(REQ_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                end else begin
                    // Broken editing: a burst of backspaces, often past the left edge.
                    repeat ($urandom_range(1, 6))
                        send(REQ_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
                end
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
